// File: rtl/battery_trimmed_mean_low_power_detect_macros.svh
// Assertion macros shared by the battery detector modules.
`ifndef BATTERY_TRIMMED_MEAN_LOW_POWER_DETECT_MACROS_SVH
`define BATTERY_TRIMMED_MEAN_LOW_POWER_DETECT_MACROS_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define BTM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define BTM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/btm_pkg.sv
// Shared types, constants and helper functions for the battery detector.
`timescale 1ns / 1ps
`default_nettype none

package btm_pkg;

    localparam int ROUND_SAMPLES_DEF = 10;
    localparam int TRIM_EACH_END_DEF = 2;

    localparam int ADC_W    = 12;
    localparam int SAMPLE_W = 14;
    localparam int MV_W     = 13;
    localparam int THRESH_W = 14;
    localparam int DEB_W    = 8;
    localparam int EVENT_W  = 2;

    localparam int DIVIDER_GAIN    = 3;
    localparam int REPORT_CLAMP_MV = 4200;

    localparam logic [THRESH_W-1:0] THRESH_RST   = THRESH_W'(3300);
    localparam logic [DEB_W-1:0]    DEBOUNCE_RST = DEB_W'(50);
    localparam logic                START_LP_RST = 1'b0;

    localparam logic [EVENT_W-1:0] EV_NONE  = 2'd0;
    localparam logic [EVENT_W-1:0] EV_ENTER = 2'd1;
    localparam logic [EVENT_W-1:0] EV_EXIT  = 2'd2;

    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_LOW_THRESHOLD = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE      = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_START_LP      = 2'd2;

    typedef struct packed {
        logic [THRESH_W-1:0] low_threshold_mv;
        logic [DEB_W-1:0]    debounce_rounds;
        logic                start_lp_wr;
        logic                start_lp_val;
    } cfg_t;

    typedef struct packed {
        logic store;
        logic sort_step;
        logic sort_odd;
        logic sum_step;
        logic div_step;
        logic eval;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic last;
    } status_t;

    // Trim per end, reduced when the configured trim would leave nothing.
    function automatic int trim_eff(input int n, input int t);
        int r;
        if (2 * t >= n) begin
            r = (n - 1) >> 1;
        end else begin
            r = t;
        end
        return r;
    endfunction

    function automatic int kept_of(input int n, input int t);
        return n - 2 * trim_eff(n, t);
    endfunction

    function automatic int sum_w_of(input int n, input int t);
        return SAMPLE_W + $clog2(kept_of(n, t));
    endfunction

endpackage

`default_nettype wire

// File: rtl/btm_regs.sv
// APB-style register file holding threshold, debounce length and start flag.
`timescale 1ns / 1ps
`default_nettype none

module btm_regs
    import btm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    logic [THRESH_W-1:0]  thresh_reg, thresh_next;
    logic [DEB_W-1:0]     deb_reg, deb_next;
    logic                 slp_reg, slp_next;
    logic                 wr_en;
    logic                 slp_wr;
    logic [REG_IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[PADDR_W-1:2];

    always_comb
    begin
        thresh_next = thresh_reg;
        deb_next    = deb_reg;
        slp_next    = slp_reg;
        slp_wr      = 1'b0;
        if (wr_en)
        begin
            unique case (idx)
                REG_LOW_THRESHOLD: thresh_next = pwdata[THRESH_W-1:0];
                REG_DEBOUNCE:      deb_next    = pwdata[DEB_W-1:0];
                REG_START_LP:
                begin
                    slp_next = pwdata[0];
                    slp_wr   = 1'b1;
                end
                default:           slp_wr      = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_LOW_THRESHOLD: prdata = PDATA_W'(thresh_reg);
            REG_DEBOUNCE:      prdata = PDATA_W'(deb_reg);
            REG_START_LP:      prdata = PDATA_W'(slp_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RST;
            deb_reg    <= DEBOUNCE_RST;
            slp_reg    <= START_LP_RST;
        end
        else
        begin
            thresh_reg <= thresh_next;
            deb_reg    <= deb_next;
            slp_reg    <= slp_next;
        end
    end

    assign cfg.low_threshold_mv = thresh_reg;
    assign cfg.debounce_rounds  = deb_reg;
    assign cfg.start_lp_wr      = slp_wr;
    assign cfg.start_lp_val     = pwdata[0];

endmodule

`default_nettype wire

// File: rtl/btm_dp.sv
// Datapath: sample store, transposition sorter, accumulator, divider, debounce.
`timescale 1ns / 1ps
`default_nettype none

`include "battery_trimmed_mean_low_power_detect_macros.svh"

module btm_dp
    import btm_pkg::*;
#(
    parameter int ROUND_SAMPLES = ROUND_SAMPLES_DEF,
    parameter int TRIM_EACH_END = TRIM_EACH_END_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [ADC_W-1:0] adc_mv,
    input  cfg_t                  cfg,
    input  cmd_t                  cmd,
    output status_t               status,
    output logic      [MV_W-1:0]  battery_mv,
    output logic                  round_done,
    output logic                  low_power,
    output logic [EVENT_W-1:0]    event_code
);

    localparam int N           = ROUND_SAMPLES;
    localparam int IDX_W       = $clog2(N);
    localparam int TRIM_EFF    = trim_eff(ROUND_SAMPLES, TRIM_EACH_END);
    localparam int KEPT        = kept_of(ROUND_SAMPLES, TRIM_EACH_END);
    localparam int SUM_W       = sum_w_of(ROUND_SAMPLES, TRIM_EACH_END);
    localparam int RECIP_SHIFT = SUM_W + $clog2(KEPT);
    localparam int RECIP_W     = SUM_W + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_MUL =
        RECIP_W'(((1 << RECIP_SHIFT) + KEPT - 1) / KEPT);

    logic [SAMPLE_W-1:0] store_reg [N];
    logic [SAMPLE_W-1:0] store_next [N];

    logic [IDX_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    ptr_reg, ptr_next;
    logic [SUM_W-1:0]    acc_reg, acc_next;
    logic [SAMPLE_W-1:0] avg_reg, avg_next;
    logic [DEB_W-1:0]    rc_reg, rc_next;
    logic                flag_reg, flag_next;
    logic                done_reg, done_next;
    logic [EVENT_W-1:0]  event_reg, event_next;

    logic [MV_W-1:0]     bat_reg;
    logic                rdone_reg;
    logic                lp_reg;
    logic [EVENT_W-1:0]  ev_out_reg;

    logic [SAMPLE_W-1:0] sample;
    logic                last;
    logic [PROD_W-1:0]   prod;
    logic [SAMPLE_W-1:0] avg_new;
    logic                qualifies;
    logic [DEB_W-1:0]    rc_inc;
    logic [MV_W-1:0]     bat_clamped;

    assign sample        = SAMPLE_W'(adc_mv) * SAMPLE_W'(DIVIDER_GAIN);
    assign last          = (count_reg == IDX_W'(N - 1));
    assign status.last   = last;

    // Division by the kept count is a multiply by its rounded-up reciprocal.
    // The shift is wide enough that the quotient is exact for every sum.
    assign prod = PROD_W'(acc_reg) * PROD_W'(RECIP_MUL);

    assign avg_new   = acc_reg[SAMPLE_W-1:0];
    assign qualifies = flag_reg ? (avg_new > cfg.low_threshold_mv)
                                : (avg_new <= cfg.low_threshold_mv);
    assign rc_inc    = rc_reg + DEB_W'(1);

    assign bat_clamped = (avg_reg > SAMPLE_W'(REPORT_CLAMP_MV))
                       ? MV_W'(REPORT_CLAMP_MV) : avg_reg[MV_W-1:0];

    // Store writes and odd-even transposition steps; pairs are disjoint per step.
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            store_next[i] = store_reg[i];
        end
        if (cmd.store)
        begin
            store_next[count_reg] = sample;
        end
        else if (cmd.sort_step)
        begin
            for (int i = 0; i < N - 1; i++)
            begin
                if (((i % 2) == int'(cmd.sort_odd)) && (store_reg[i+1] < store_reg[i]))
                begin
                    store_next[i]   = store_reg[i+1];
                    store_next[i+1] = store_reg[i];
                end
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        ptr_next   = ptr_reg;
        acc_next   = acc_reg;
        avg_next   = avg_reg;
        rc_next    = rc_reg;
        flag_next  = flag_reg;
        done_next  = done_reg;
        event_next = event_reg;

        if (cmd.store)
        begin
            count_next = last ? '0 : count_reg + IDX_W'(1);
            ptr_next   = IDX_W'(TRIM_EFF);
            acc_next   = '0;
            done_next  = last;
            event_next = EV_NONE;
        end

        if (cmd.sum_step)
        begin
            acc_next = acc_reg + SUM_W'(store_reg[ptr_reg]);
            ptr_next = ptr_reg + IDX_W'(1);
        end

        if (cmd.div_step)
        begin
            acc_next = SUM_W'(prod >> RECIP_SHIFT);
        end

        if (cmd.eval)
        begin
            avg_next = avg_new;
            if (qualifies)
            begin
                if (rc_inc >= cfg.debounce_rounds)
                begin
                    rc_next    = '0;
                    flag_next  = !flag_reg;
                    event_next = flag_reg ? EV_EXIT : EV_ENTER;
                end
                else
                begin
                    rc_next = rc_inc;
                end
            end
            else
            begin
                rc_next = '0;
            end
        end

        if (cfg.start_lp_wr)
        begin
            flag_next = cfg.start_lp_val;
            rc_next   = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N; i++)
        begin
            store_reg[i] <= store_next[i];
        end
        ptr_reg <= ptr_next;
        acc_reg <= acc_next;
        if (cmd.out_load)
        begin
            bat_reg    <= bat_clamped;
            rdone_reg  <= done_reg;
            lp_reg     <= flag_reg;
            ev_out_reg <= event_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            avg_reg   <= '0;
            rc_reg    <= '0;
            flag_reg  <= START_LP_RST;
            done_reg  <= 1'b0;
            event_reg <= EV_NONE;
        end
        else
        begin
            count_reg <= count_next;
            avg_reg   <= avg_next;
            rc_reg    <= rc_next;
            flag_reg  <= flag_next;
            done_reg  <= done_next;
            event_reg <= event_next;
        end
    end

    assign battery_mv = bat_reg;
    assign round_done = rdone_reg;
    assign low_power  = lp_reg;
    assign event_code = ev_out_reg;

    `BTM_ASSERT_IMP(a_event_needs_round, event_reg != EV_NONE, done_reg, "event without a round")
    `BTM_ASSERT_IMP(a_count_range, 1'b1, count_reg <= IDX_W'(N - 1), "sample count out of range")

endmodule

`default_nettype wire

// File: rtl/btm_ctrl.sv
// Controller: sequences store, sort, sum, divide, evaluate and result hand-off.
`timescale 1ns / 1ps
`default_nettype none

`include "battery_trimmed_mean_low_power_detect_macros.svh"

module btm_ctrl
    import btm_pkg::*;
#(
    parameter int ROUND_SAMPLES = ROUND_SAMPLES_DEF,
    parameter int TRIM_EACH_END = TRIM_EACH_END_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    input  status_t   status,
    output cmd_t      cmd
);

    localparam int N      = ROUND_SAMPLES;
    localparam int KEPT   = kept_of(ROUND_SAMPLES, TRIM_EACH_END);
    localparam int STEP_W = $clog2(N);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SORT   = 3'd1;
    localparam logic [2:0] S_SUM    = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_EVAL   = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic              accept;
    logic              finish_stall;

    assign in_ready     = (state_reg == S_IDLE);
    assign accept       = in_valid && in_ready;
    assign finish_stall = (state_reg == S_FINISH) && out_valid_reg && !out_ready;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                step_next = '0;
                if (accept)
                begin
                    cmd.store  = 1'b1;
                    state_next = status.last ? S_SORT : S_FINISH;
                end
            end
            S_SORT:
            begin
                cmd.sort_step = 1'b1;
                cmd.sort_odd  = step_reg[0];
                if (step_reg == STEP_W'(N - 1))
                begin
                    step_next  = '0;
                    state_next = S_SUM;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            S_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (step_reg == STEP_W'(KEPT - 1))
                begin
                    step_next  = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            S_DIV:
            begin
                // The reciprocal multiply is combinational; its quotient is registered into the accumulator.
                cmd.div_step = 1'b1;
                state_next   = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // The finished word waits here until the output register frees up.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `BTM_ASSERT_NXT(a_last_sorts, accept && status.last, state_reg == S_SORT, "sort not started")
    `BTM_ASSERT_NXT(a_div_to_eval, state_reg == S_DIV, state_reg == S_EVAL, "eval skipped")
    `BTM_ASSERT_NXT(a_hold_finish, finish_stall, state_reg == S_FINISH, "finish left while full")

endmodule

`default_nettype wire

// File: rtl/battery_trimmed_mean_low_power_detect.sv
// Top level of the battery trimmed-mean low-power detector.
//
// Input channel (in_valid/in_ready, adc_mv) takes one battery ADC word per
// detect tick; each word yields exactly one output word on the output channel
// (out_valid/out_ready: battery_mv, round_done, low_power, event_code).
// A word that does not close a round goes from idle to the finish state and is
// loaded into the output register from there; no new word is taken meanwhile.
// The word that closes a round passes through ROUND_SAMPLES steps of the
// odd-even sorter, kept steps of the single accumulator (10 and 6 at the
// defaults), one reciprocal multiply, one evaluate and one load; the next word
// can be accepted once the controller is back in idle.
// in_ready is high only while the controller is idle; a finished word sits in
// the output register so the next input word can be taken while it waits.
// If the receiver stalls, the following word is computed and then held until
// the output register is taken. Reset clears the sample count, debounce count
// and average, loads the low-power flag from the start_low_power reset value
// and empties the output. Registers are to be written over the APB-style port
// only while the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module battery_trimmed_mean_low_power_detect
    import btm_pkg::*;
#(
    parameter int ROUND_SAMPLES = ROUND_SAMPLES_DEF,
    parameter int TRIM_EACH_END = TRIM_EACH_END_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [ADC_W-1:0]   adc_mv,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic      [MV_W-1:0]    battery_mv,
    output logic                    round_done,
    output logic                    low_power,
    output logic      [EVENT_W-1:0] event_code
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    btm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    btm_ctrl #(
        .ROUND_SAMPLES (ROUND_SAMPLES),
        .TRIM_EACH_END (TRIM_EACH_END)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    btm_dp #(
        .ROUND_SAMPLES (ROUND_SAMPLES),
        .TRIM_EACH_END (TRIM_EACH_END)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .adc_mv     (adc_mv),
        .cfg        (cfg),
        .cmd        (cmd),
        .status     (status),
        .battery_mv (battery_mv),
        .round_done (round_done),
        .low_power  (low_power),
        .event_code (event_code)
    );

endmodule

`default_nettype wire

// File: test/tb_battery_trimmed_mean_low_power_detect.sv
// Testbench for the battery trimmed-mean low-power detector: directed and random rounds.
`timescale 1ns / 1ps

module tb_battery_trimmed_mean_low_power_detect;
    import btm_pkg::*;

    localparam int ROUND_LEN = ROUND_SAMPLES_DEF;
    localparam int TRIM_ENDS = TRIM_EACH_END_DEF;
    localparam int MAX_SAMPLE_MV = 12285;
    localparam int SAMPLE_TARGET = 1400;
    localparam int IDLE_LIMIT = 4000;
    localparam int TAIL_CYCLES = 60;
    localparam int MAX_PRINTED = 50;

    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int SHAPE_NEAR = 0;
    localparam int SHAPE_FLAT = 1;
    localparam int SHAPE_NOISE = 2;

    typedef struct packed {
        logic [MV_W-1:0]    mv;
        logic               done;
        logic               lp;
        logic [EVENT_W-1:0] ev;
    } detect_word_t;

    // Tracks the detector state and holds the words it should produce, oldest first.
    class round_scoreboard;
        logic [THRESH_W-1:0] threshold;
        logic [DEB_W-1:0]    debounce;
        logic                lp_flag;
        logic [DEB_W-1:0]    qual_rounds;
        logic [SAMPLE_W-1:0] round_buf [ROUND_LEN];
        logic [SAMPLE_W-1:0] avg_mv;
        int                  fill;
        detect_word_t        pending_words [$];
        int                  mismatch_count;
        int                  rounds_seen;
        int                  entries;
        int                  exits;

        function new();
            threshold = THRESH_RST;
            debounce = DEBOUNCE_RST;
            lp_flag = START_LP_RST;
            qual_rounds = '0;
            avg_mv = '0;
            fill = 0;
            foreach (round_buf[k])
            begin
                round_buf[k] = '0;
            end
            mismatch_count = 0;
            rounds_seen = 0;
            entries = 0;
            exits = 0;
        endfunction

        task report_mismatch(input string msg);
            mismatch_count++;
            if (mismatch_count <= MAX_PRINTED)
            begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
        endtask

        function void write_reg(input logic [REG_IDX_W-1:0] idx,
                                input logic [PDATA_W-1:0] value);
            case (idx)
                REG_LOW_THRESHOLD: threshold = value[THRESH_W-1:0];
                REG_DEBOUNCE:      debounce = value[DEB_W-1:0];
                REG_START_LP:
                begin
                    lp_flag = value[0];
                    qual_rounds = '0;
                end
                default: ;
            endcase
        endfunction

        function void note_sample(input logic [ADC_W-1:0] adc);
            logic [SAMPLE_W-1:0] sorted [ROUND_LEN];
            logic [SAMPLE_W-1:0] tmp;
            logic [31:0]         total;
            logic                qualifies;
            int                  trim;
            int                  kept;
            int                  a;
            int                  b;
            detect_word_t        w;
            w.done = 1'b0;
            w.ev = EV_NONE;
            round_buf[fill] = SAMPLE_W'(int'(adc) * DIVIDER_GAIN);
            fill++;
            if (fill == ROUND_LEN)
            begin
                fill = 0;
                w.done = 1'b1;
                rounds_seen++;
                sorted = round_buf;
                for (a = 1; a < ROUND_LEN; a++)
                begin
                    for (b = a; b > 0 && sorted[b] < sorted[b-1]; b--)
                    begin
                        tmp = sorted[b];
                        sorted[b] = sorted[b-1];
                        sorted[b-1] = tmp;
                    end
                end
                // Trimming that would drop every sample shrinks to leave at least one.
                trim = TRIM_ENDS;
                if (2 * trim >= ROUND_LEN)
                begin
                    trim = (ROUND_LEN - 1) / 2;
                end
                kept = ROUND_LEN - 2 * trim;
                total = '0;
                for (a = trim; a < trim + kept; a++)
                begin
                    total += sorted[a];
                end
                avg_mv = SAMPLE_W'(total / kept);
                qualifies = lp_flag ? (avg_mv > threshold) : (avg_mv <= threshold);
                if (qualifies)
                begin
                    qual_rounds = qual_rounds + 1'b1;
                    // A debounce of zero acts like one since the count is at least one here.
                    if (qual_rounds >= debounce)
                    begin
                        qual_rounds = '0;
                        if (lp_flag)
                        begin
                            lp_flag = 1'b0;
                            w.ev = EV_EXIT;
                            exits++;
                        end
                        else
                        begin
                            lp_flag = 1'b1;
                            w.ev = EV_ENTER;
                            entries++;
                        end
                    end
                end
                else
                begin
                    qual_rounds = '0;
                end
            end
            w.mv = (avg_mv > SAMPLE_W'(REPORT_CLAMP_MV)) ? MV_W'(REPORT_CLAMP_MV)
                                                          : avg_mv[MV_W-1:0];
            w.lp = lp_flag;
            pending_words.push_back(w);
        endfunction

        task check_word(input detect_word_t got);
            detect_word_t want;
            if (pending_words.size() == 0)
            begin
                report_mismatch($sformatf("word with nothing expected, battery_mv=%0d",
                                          got.mv));
                return;
            end
            want = pending_words.pop_front();
            if (got.mv !== want.mv)
            begin
                report_mismatch($sformatf("battery_mv %0d, expected %0d", got.mv, want.mv));
            end
            if (got.done !== want.done)
            begin
                report_mismatch($sformatf("round_done %b, expected %b", got.done, want.done));
            end
            if (got.lp !== want.lp)
            begin
                report_mismatch($sformatf("low_power %b, expected %b", got.lp, want.lp));
            end
            if (got.ev !== want.ev)
            begin
                report_mismatch($sformatf("event_code %0d, expected %0d", got.ev, want.ev));
            end
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    logic [ADC_W-1:0]   adc_mv;
    logic               out_valid;
    logic               out_ready;
    logic [MV_W-1:0]    battery_mv;
    logic               round_done;
    logic               low_power;
    logic [EVENT_W-1:0] event_code;

    round_scoreboard sb;
    int  samples_sent;
    int  settings_used;
    bit  in_quiet;
    bit  out_quiet;

    battery_trimmed_mean_low_power_detect dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .adc_mv     (adc_mv),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .battery_mv (battery_mv),
        .round_done (round_done),
        .low_power  (low_power),
        .event_code (event_code)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int draw_gap(input bit quiet);
        return quiet ? 0 : int'($urandom_range(0, 16));
    endfunction

    task automatic send_sample(input logic [ADC_W-1:0] value);
        int gap;
        gap = draw_gap(in_quiet);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        adc_mv <= value;
        @(posedge clk);
        while (!(in_valid && in_ready)) @(posedge clk);
        sb.note_sample(value);
        samples_sent++;
        if ($urandom_range(0, 39) == 0)
        begin
            in_quiet = !in_quiet;
        end
    endtask

    task automatic reg_write(input logic [REG_IDX_W-1:0] idx,
                             input logic [PDATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        sb.write_reg(idx, value);
        @(posedge clk);
    endtask

    task automatic configure(input int thr, input int deb, input bit start_lp);
        reg_write(REG_LOW_THRESHOLD, PDATA_W'(thr));
        reg_write(REG_DEBOUNCE, PDATA_W'(deb));
        reg_write(REG_START_LP, PDATA_W'(start_lp));
        settings_used++;
    endtask

    // Registers change only once every expected word has come back.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending_words.size() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    // One round of ten readings shaped around a battery level in millivolts.
    task automatic send_round(input int level, input int shape);
        int center;
        int v;
        int k;
        int lo_slot;
        int hi_slot;
        center = level / 3;
        lo_slot = $urandom_range(0, ROUND_LEN - 1);
        hi_slot = $urandom_range(0, ROUND_LEN - 1);
        for (k = 0; k < ROUND_LEN; k++)
        begin
            if (shape == SHAPE_NOISE)
            begin
                v = $urandom_range(0, 4095);
            end
            else if (shape == SHAPE_FLAT)
            begin
                v = center;
            end
            else if (k == lo_slot)
            begin
                v = $urandom_range(0, center);
            end
            else if (k == hi_slot)
            begin
                v = $urandom_range(center, 4095);
            end
            else
            begin
                v = center + int'($urandom_range(0, 6)) - 3;
            end
            if (v < 0)
            begin
                v = 0;
            end
            if (v > 4095)
            begin
                v = 4095;
            end
            send_sample(v[ADC_W-1:0]);
        end
    endtask

    // Runs of rounds on one side of the threshold, so the debounce count can build up.
    task automatic run_rounds(input int rounds);
        bit below;
        int r;
        int level;
        int pick;
        int shape;
        below = $urandom_range(0, 1);
        for (r = 0; r < rounds; r++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                below = !below;
            end
            if (below)
            begin
                level = int'(sb.threshold) - int'($urandom_range(0, 150));
            end
            else
            begin
                level = int'(sb.threshold) + 1 + int'($urandom_range(0, 150));
            end
            if (level < 0)
            begin
                level = 0;
            end
            if (level > MAX_SAMPLE_MV)
            begin
                level = MAX_SAMPLE_MV;
            end
            pick = $urandom_range(0, 9);
            shape = (pick == 0) ? SHAPE_NOISE : (pick == 1) ? SHAPE_FLAT : SHAPE_NEAR;
            send_round(level, shape);
        end
    endtask

    task automatic random_setting();
        int thr;
        int deb;
        int pick;
        pick = $urandom_range(0, 15);
        thr = (pick == 0) ? 0 : (pick == 1) ? MAX_SAMPLE_MV : (pick == 2) ? 16383
            : int'($urandom_range(1500, 6000));
        pick = $urandom_range(0, 19);
        deb = (pick == 0) ? 0 : (pick == 1) ? 255 : int'($urandom_range(1, 5));
        if ($urandom_range(0, 3) != 0)
        begin
            reg_write(REG_LOW_THRESHOLD, PDATA_W'(thr));
        end
        if ($urandom_range(0, 3) != 0)
        begin
            reg_write(REG_DEBOUNCE, PDATA_W'(deb));
        end
        if ($urandom_range(0, 3) != 0)
        begin
            reg_write(REG_START_LP, PDATA_W'($urandom_range(0, 1)));
        end
        settings_used++;
    endtask

    initial
    begin : main_flow
        logic [ADC_W-1:0] edge_values [ROUND_LEN];
        int k;
        edge_values = '{12'd0, 12'd4095, 12'd0, 12'd4095, 12'hAAA,
                        12'h555, 12'd1, 12'd4094, 12'd2048, 12'd2047};
        sb = new();
        samples_sent = 0;
        settings_used = 1;
        in_quiet = 1'b0;
        out_quiet = 1'b0;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        adc_mv <= '0;
        out_ready <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes first; battery_mv reads zero until this round closes.
        for (k = 0; k < ROUND_LEN; k++)
        begin
            send_sample(edge_values[k]);
        end
        // Every reading scales to exactly the reset threshold, which counts as low.
        for (k = 0; k < ROUND_LEN; k++)
        begin
            send_sample(12'd1100);
        end
        run_rounds(6);

        settle();
        configure(3300, 1, 1'b0);
        run_rounds(12);
        settle();
        configure(0, 2, 1'b1);
        run_rounds(12);
        settle();
        configure(16383, 3, 1'b0);
        run_rounds(10);
        settle();
        configure(MAX_SAMPLE_MV, 0, 1'b1);
        run_rounds(10);
        settle();
        // The spare address must leave all state alone.
        reg_write(REG_UNUSED, PDATA_W'($urandom()));
        configure(int'($urandom_range(0, MAX_SAMPLE_MV)), 255, 1'($urandom_range(0, 1)));
        run_rounds(8);

        while (samples_sent < SAMPLE_TARGET)
        begin
            settle();
            random_setting();
            run_rounds($urandom_range(8, 20));
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending_words.size() != 0)
        begin
            sb.report_mismatch($sformatf("%0d words never arrived", sb.pending_words.size()));
        end
        $display("Run covered %0d samples in %0d rounds across %0d register settings.",
                 samples_sent, sb.rounds_seen, settings_used);
        $display("Low-power entries seen: %0d, exits seen: %0d, mismatches: %0d.",
                 sb.entries, sb.exits, sb.mismatch_count);
        if (sb.mismatch_count == 0)
        begin
            $display("PASS battery_trimmed_mean_low_power_detect");
        end
        else
        begin
            $display("FAIL battery_trimmed_mean_low_power_detect");
        end
        $finish;
    end

    initial
    begin : result_sink
        int stall;
        detect_word_t got;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_gap(out_quiet);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready)) @(posedge clk);
            got.mv = battery_mv;
            got.done = round_done;
            got.lp = low_power;
            got.ev = event_code;
            sb.check_word(got);
            if ($urandom_range(0, 39) == 0)
            begin
                out_quiet = !out_quiet;
            end
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        wait (rst_n === 1'b1);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (psel && penable && pready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("Timed out after %0d cycles with no word or register transfer.", IDLE_LIMIT);
        $display("FAIL battery_trimmed_mean_low_power_detect");
        $finish;
    end

endmodule
